// ===== design/upd_pkg.sv =====
// shared types, constants and helpers for the url percent decoder
`default_nettype none

package upd_pkg;

   // character codes
   localparam logic [7:0] CHR_PCT   = 8'h25;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_SPACE = 8'h20;

   // most decoded bytes one input beat can release
   localparam int MAX_BYTES = 3;

   // group queue sizing
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

   // escape progress
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } upd_phase_type;

   // bytes released by one input beat, in output order
   typedef struct packed {
      logic [1:0]                 count;
      logic [MAX_BYTES-1:0][7:0]  bytes;
      logic                       last;
   } upd_group_type;

   // front to queue
   typedef struct packed {
      logic          push;
      upd_group_type group;
   } upd_push_type;

   // queue to back
   typedef struct packed {
      logic          valid;
      upd_group_type group;
   } upd_head_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h61) begin
         v = c - 8'h57;
      end else if (c >= 8'h41) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h30;
      end
      return v[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/upd_front.sv =====
// front end: escape tracking and grouping of the bytes each input beat releases
`default_nettype none

module upd_front import upd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire logic [7:0]   req_byte,
   input  wire logic         req_last,
   output upd_push_type      push
);

   upd_phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   logic          accept;
   logic [1:0]    grp_count;
   logic [MAX_BYTES-1:0][7:0] grp_bytes;

   assign accept = req_valid && !req_stall;

   // escape state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   // next phase and bytes released by this beat
   always_comb begin
      phase_in  = PH_IDLE;
      held_in   = held_ff;
      grp_count = '0;
      grp_bytes = '0;

      unique case (phase_ff)
         PH_PCT: begin
            if (is_hex(req_byte)) begin
               held_in  = req_byte;
               phase_in = PH_DIGIT;
            end else begin
               grp_bytes[grp_count] = CHR_PCT;
               grp_count = grp_count + 2'd1;
            end
         end
         PH_DIGIT: begin
            if (is_hex(req_byte)) begin
               grp_bytes[grp_count] = {hex_val(held_ff), hex_val(req_byte)};
               grp_count = grp_count + 2'd1;
            end else begin
               grp_bytes[grp_count] = CHR_PCT;
               grp_count = grp_count + 2'd1;
               grp_bytes[grp_count] = held_ff;
               grp_count = grp_count + 2'd1;
            end
         end
         default: begin
         end
      endcase

      // the byte is handled as a fresh character unless it extended an escape
      if (!(phase_ff == PH_PCT || phase_ff == PH_DIGIT) || !is_hex(req_byte)) begin
         if (req_byte == CHR_PCT) begin
            phase_in = PH_PCT;
         end else if (req_byte == CHR_PLUS) begin
            grp_bytes[grp_count] = CHR_SPACE;
            grp_count = grp_count + 2'd1;
         end else begin
            grp_bytes[grp_count] = req_byte;
            grp_count = grp_count + 2'd1;
         end
      end

      // end of string flushes anything still held
      if (req_last) begin
         if (phase_in == PH_PCT) begin
            grp_bytes[grp_count] = CHR_PCT;
            grp_count = grp_count + 2'd1;
         end else if (phase_in == PH_DIGIT) begin
            grp_bytes[grp_count] = CHR_PCT;
            grp_count = grp_count + 2'd1;
            grp_bytes[grp_count] = held_in;
            grp_count = grp_count + 2'd1;
         end
         phase_in = PH_IDLE;
         held_in  = '0;
      end
   end

   assign push.push        = accept && (grp_count != 2'd0);
   assign push.group.count = grp_count;
   assign push.group.bytes = grp_bytes;
   assign push.group.last  = req_last;

   // a string end always releases at least one byte
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |-> push.push)
      else $error("last beat released no byte");

   // escape state is idle after a string end
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (phase_ff == PH_IDLE))
      else $error("escape pending after string end");

   // a percent that opens an escape from idle releases nothing
   a_hold_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_IDLE && phase_in == PH_PCT) |-> !push.push)
      else $error("percent start released a byte");

endmodule

`default_nettype wire

// ===== design/upd_queue.sv =====
// short queue of byte groups between front and back
`default_nettype none

module upd_queue import upd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire upd_push_type push,
   input  wire logic         pop,
   output upd_head_type      head,
   output logic              full
);

   upd_group_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_FILL_W-1:0]   fill_ff, fill_in;
   logic                      do_push, do_pop;

   assign full    = (fill_ff == QUEUE_FILL_W'(QUEUE_DEPTH));
   assign do_push = push.push && !full;
   assign do_pop  = pop && (fill_ff != '0);

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QUEUE_FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QUEUE_FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // group storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.group;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.group = entry_ff[rd_ptr_ff];

   // a push is never offered while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.push)
      else $error("push into full queue");

   // a pop is never asked of an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   // pointers and fill agree
   a_fill_match: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill");

endmodule

`default_nettype wire

// ===== design/upd_back.sv =====
// back end: sends the bytes of each queued group one beat at a time
`default_nettype none

module upd_back import upd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire upd_head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       final_byte;
   logic       accept;

   assign final_byte = (idx_ff == head.group.count - 2'd1);
   assign rsp_valid  = head.valid;
   assign rsp_byte   = head.group.bytes[idx_ff];
   assign rsp_last   = head.group.last && final_byte;
   assign accept     = rsp_valid && !rsp_stall;
   assign pop        = accept && final_byte;

   // position within the current group
   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         idx_in = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // the position never runs past the group it walks
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> (idx_ff < head.group.count))
      else $error("byte position beyond group");

   // position restarts after each group
   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == 2'd0))
      else $error("byte position not restarted");

   // an idle back end sits at the start of a group
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head.valid |-> (idx_ff == 2'd0))
      else $error("byte position moved with nothing queued");

endmodule

`default_nettype wire

// ===== design/url_percent_decoder.sv =====
// top level of the streaming url percent decoder
`default_nettype none

// Decodes a url-encoded byte stream: "%hh" (either case) becomes one byte, '+'
// becomes a space, everything else passes through; a broken or unfinished
// escape is sent out as received. req_last ends a string and the final
// decoded byte carries rsp_last. One input beat is taken per cycle; a beat
// releases zero to three bytes, which leave one per cycle while rsp_stall is
// low, so the input stalls only while the four-entry group queue between the
// escape front end and the byte sender is full. The bytes a beat releases are
// registered in the group queue before they go out.
module url_percent_decoder import upd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_byte,
   input  wire logic         req_last,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last
);

   upd_push_type push;
   upd_head_type head;
   logic         pop;
   logic         full;

   assign req_stall = full;

   // escape tracking
   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .push      (push)
   );

   // group queue
   upd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   // byte sender
   upd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/tb_url_percent_decoder.sv =====
// self-checking testbench for the streaming url percent decoder
`default_nettype none

module tb_url_percent_decoder;
   import upd_pkg::*;

   // cycles without any accepted beat before the run is abandoned
   localparam int STALL_LIMIT = 2000;
   // items per random phase
   localparam int PHASE_ITEMS = 120;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_byte;
   logic       rsp_last;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   // tracks escape progress and holds the decoded bytes still owed by the block
   class decode_scoreboard;
      logic [8:0]    owed_bytes[$];   // {last, byte}
      upd_phase_type phase;
      logic [7:0]    held_digit;
      int            mismatches;

      function new();
         phase = PH_IDLE;
         held_digit = 8'h00;
         mismatches = 0;
      endfunction

      function logic hex_digit(input logic [7:0] c);
         logic [7:0] f;
         f = c | 8'h20;
         return (c >= "0" && c <= "9") || (f >= "a" && f <= "f");
      endfunction

      function logic [3:0] nibble(input logic [7:0] c);
         logic [7:0] f;
         f = c | 8'h20;
         if (c <= "9") begin
            return 4'(c - "0");
         end
         return 4'(f - "a" + 8'd10);
      endfunction

      function void owe(input logic [7:0] b);
         owed_bytes.push_back({1'b0, b});
      endfunction

      // a character outside any escape
      function void plain_char(input logic [7:0] c);
         if (c == CHR_PCT) begin
            phase = PH_PCT;
         end else if (c == CHR_PLUS) begin
            owe(CHR_SPACE);
         end else begin
            owe(c);
         end
      endfunction

      function void note_beat(input logic [7:0] c, input logic l);
         int         before_cnt;
         logic [8:0] tail;
         before_cnt = owed_bytes.size();
         case (phase)
            PH_PCT: begin
               if (hex_digit(c)) begin
                  held_digit = c;
                  phase = PH_DIGIT;
               end else begin
                  owe(CHR_PCT);
                  phase = PH_IDLE;
                  plain_char(c);
               end
            end
            PH_DIGIT: begin
               phase = PH_IDLE;
               if (hex_digit(c)) begin
                  owe({nibble(held_digit), nibble(c)});
               end else begin
                  owe(CHR_PCT);
                  owe(held_digit);
                  plain_char(c);
               end
            end
            default: begin
               phase = PH_IDLE;
               plain_char(c);
            end
         endcase
         // end of string flushes a pending escape and marks the final byte
         if (l) begin
            if (phase == PH_PCT) begin
               owe(CHR_PCT);
            end else if (phase == PH_DIGIT) begin
               owe(CHR_PCT);
               owe(held_digit);
            end
            phase = PH_IDLE;
            held_digit = 8'h00;
            if (owed_bytes.size() > before_cnt) begin
               tail = owed_bytes.pop_back();
               tail[8] = 1'b1;
               owed_bytes.push_back(tail);
            end
         end
      endfunction

      task report(input string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task check_byte(input logic [7:0] b, input logic l);
         logic [8:0] want;
         if (owed_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %0b", b, l));
         end else begin
            want = owed_bytes.pop_front();
            if (b !== want[7:0]) begin
               report($sformatf("byte %02h, wanted %02h", b, want[7:0]));
            end
            if (l !== want[8]) begin
               report($sformatf("last %0b on byte %02h, wanted %0b", l, b, want[8]));
            end
         end
      endtask

      task flush_missing();
         logic [8:0] want;
         while (owed_bytes.size() != 0) begin
            want = owed_bytes.pop_front();
            report($sformatf("byte %02h last %0b never arrived", want[7:0], want[8]));
         end
      endtask

      function int pending();
         return owed_bytes.size();
      endfunction
   endclass

   decode_scoreboard sb = new();

   url_percent_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

   // clock
   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // beat monitors on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_beat(req_byte, req_last);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_byte(rsp_byte, rsp_last);
         end
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no accepted beat
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   // one input beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte  <= b;
      req_last  <= l;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic end_flag);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(s[i], end_flag && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] pick_hex();
      int r;
      r = $urandom_range(21);
      if (r < 10) begin
         return 8'("0" + r);
      end else if (r < 16) begin
         return 8'("A" + r - 10);
      end
      return 8'("a" + r - 16);
   endfunction

   // a string built mostly from escapes and plain text, with broken escapes and noise
   task automatic send_random_string();
      logic [7:0] text[$];
      int         tokens;
      int         kind;
      logic       end_flag;
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            text.push_back(CHR_PCT);
            text.push_back(pick_hex());
            text.push_back(pick_hex());
         end else if (kind < 40) begin
            text.push_back(CHR_PLUS);
         end else if (kind < 60) begin
            text.push_back(8'($urandom_range(8'h21, 8'h7e)));
         end else if (kind < 75) begin
            text.push_back(8'($urandom_range(1, 255)));
         end else if (kind < 85) begin
            text.push_back(CHR_PCT);
         end else begin
            text.push_back(CHR_PCT);
            text.push_back(pick_hex());
         end
      end
      end_flag = ($urandom_range(99) < 85);
      for (int i = 0; i < text.size(); i++) begin
         send_beat(text[i], end_flag && (i == text.size() - 1));
      end
   endtask

   // sender pause until every owed byte has come out
   task automatic drain();
      req_valid <= 1'b0;
      // let the monitor see the final accepted beat first
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // main sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: both hex cases, zero byte, plus, broken escapes, flush at end
      send_text("%aF%00+", 1'b0);
      send_text("%4G", 1'b0);
      send_text("%%+", 1'b0);
      send_text("%4%41", 1'b0);
      send_beat(CHR_PCT, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'hff, 1'b1);
      send_text("%", 1'b1);
      send_text("%4", 1'b1);
      send_beat(8'h01, 1'b1);
      drain();

      // sender idles more rarely than receiver
      send_idle_pct = 33;
      recv_idle_pct = 58;
      while (items_sent < 30 + PHASE_ITEMS) begin
         send_random_string();
      end
      drain();

      // the other way round
      send_idle_pct = 58;
      recv_idle_pct = 33;
      while (items_sent < 30 + 2 * PHASE_ITEMS) begin
         send_random_string();
      end
      drain();

      // no idling, opening with a long receiver hold-off to back up the input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = 80;
      while (items_sent < 30 + 3 * PHASE_ITEMS) begin
         send_random_string();
      end
      send_text("%", 1'b1);
      drain();
      repeat (8) @(posedge clock);

      sb.flush_missing();
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/upd_pkg.sv
design/upd_front.sv
design/upd_queue.sv
design/upd_back.sv
design/url_percent_decoder.sv
tb/tb_url_percent_decoder.sv
